[rtl/dmpid_pkg.sv]
package dmpid_pkg;

	localparam logic [1:0] CMD_COMPUTE = 2'd0;
	localparam logic [1:0] CMD_SET     = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	localparam logic STS_OK        = 1'b0;
	localparam logic STS_BAD_MOTOR = 1'b1;

	localparam logic [2:0] REG_KP0       = 3'd0;
	localparam logic [2:0] REG_KI0       = 3'd1;
	localparam logic [2:0] REG_KD0       = 3'd2;
	localparam logic [2:0] REG_KP1       = 3'd3;
	localparam logic [2:0] REG_KI1       = 3'd4;
	localparam logic [2:0] REG_KD1       = 3'd5;
	localparam logic [2:0] REG_MAX_PULSE = 3'd6;

	localparam int GAIN_SETS = 2;
	localparam int SPEED_W   = 16;
	localparam int GAIN_W    = 16;
	localparam int PULSE_W   = 15;
	localparam int FRAC_W    = 8;
	localparam int ERR_W     = SPEED_W + 1;
	localparam int ACC_W     = PULSE_W + FRAC_W + 1;
	localparam int DRIVE_W   = ACC_W - FRAC_W;
	localparam int PA_W      = ERR_W + 1;
	localparam int DA_W      = ERR_W + 2;
	localparam int PP_W      = GAIN_W + PA_W;
	localparam int PI_W      = GAIN_W + ERR_W;
	localparam int PD_W      = GAIN_W + DA_W;
	localparam int SUM_W     = PD_W + 3;

	localparam logic [GAIN_W-1:0]  KP_RESET        = 16'd256;
	localparam logic [GAIN_W-1:0]  KI_RESET        = 16'd0;
	localparam logic [GAIN_W-1:0]  KD_RESET        = 16'd0;
	localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = 15'd32767;

	typedef struct packed {
		logic [1:0]                cmd;
		logic [1:0]                motor_sel;
		logic signed [SPEED_W-1:0] measured_speed;
		logic signed [SPEED_W-1:0] new_target;
	} req_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      status;
	} rsp_t;

	typedef struct packed {
		logic [GAIN_SETS-1:0][GAIN_W-1:0] kp;
		logic [GAIN_SETS-1:0][GAIN_W-1:0] ki;
		logic [GAIN_SETS-1:0][GAIN_W-1:0] kd;
		logic [PULSE_W-1:0]               max_pulse;
	} cfg_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] acc;
		logic signed [ERR_W-1:0] e1;
		logic signed [ERR_W-1:0] e2;
	} loop_ent_t;

	typedef struct packed {
		logic      wr;
		logic      clr;
		logic [1:0] sel;
		loop_ent_t data;
	} loop_op_t;

	typedef struct packed {
		logic                      en;
		logic                      all;
		logic [1:0]                sel;
		logic signed [SPEED_W-1:0] data;
	} tgt_op_t;

endpackage

[rtl/dmpid_regs.sv]
module dmpid_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output dmpid_pkg::cfg_t     cfg
);

	dmpid_pkg::cfg_t cfg_q;
	logic            wr_en;
	logic [2:0]      reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp        <= {dmpid_pkg::KP_RESET, dmpid_pkg::KP_RESET};
			cfg_q.ki        <= {dmpid_pkg::KI_RESET, dmpid_pkg::KI_RESET};
			cfg_q.kd        <= {dmpid_pkg::KD_RESET, dmpid_pkg::KD_RESET};
			cfg_q.max_pulse <= dmpid_pkg::MAX_PULSE_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				dmpid_pkg::REG_KP0:       cfg_q.kp[0]     <= pwdata[15:0];
				dmpid_pkg::REG_KI0:       cfg_q.ki[0]     <= pwdata[15:0];
				dmpid_pkg::REG_KD0:       cfg_q.kd[0]     <= pwdata[15:0];
				dmpid_pkg::REG_KP1:       cfg_q.kp[1]     <= pwdata[15:0];
				dmpid_pkg::REG_KI1:       cfg_q.ki[1]     <= pwdata[15:0];
				dmpid_pkg::REG_KD1:       cfg_q.kd[1]     <= pwdata[15:0];
				dmpid_pkg::REG_MAX_PULSE: cfg_q.max_pulse <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			dmpid_pkg::REG_KP0:       prdata = 32'(cfg_q.kp[0]);
			dmpid_pkg::REG_KI0:       prdata = 32'(cfg_q.ki[0]);
			dmpid_pkg::REG_KD0:       prdata = 32'(cfg_q.kd[0]);
			dmpid_pkg::REG_KP1:       prdata = 32'(cfg_q.kp[1]);
			dmpid_pkg::REG_KI1:       prdata = 32'(cfg_q.ki[1]);
			dmpid_pkg::REG_KD1:       prdata = 32'(cfg_q.kd[1]);
			dmpid_pkg::REG_MAX_PULSE: prdata = 32'(cfg_q.max_pulse);
			default:                  prdata = 32'd0;
		endcase
	end

endmodule

[rtl/dmpid_tgt_mem.sv]
module dmpid_tgt_mem #(
	parameter int MOTORS = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rd_en,
	input  logic [1:0]                           rd_sel,
	input  dmpid_pkg::tgt_op_t                   op,
	output logic signed [dmpid_pkg::SPEED_W-1:0] rd_data
);

	localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

	// An entry without its valid bit follows the last target written to all motors.
	logic signed [dmpid_pkg::SPEED_W-1:0] mem_q [MOTORS];
	logic [MOTORS-1:0]                    vld_q;
	logic signed [dmpid_pkg::SPEED_W-1:0] bcast_q;
	logic signed [dmpid_pkg::SPEED_W-1:0] rd_data_q;
	logic signed [dmpid_pkg::SPEED_W-1:0] rd_bcast_q;
	logic                                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (op.en && !op.all) begin
			mem_q[op.sel[IDX_W-1:0]] <= op.data;
		end
		if (rd_en) begin
			rd_data_q  <= mem_q[rd_sel[IDX_W-1:0]];
			rd_bcast_q <= bcast_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			bcast_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_sel[IDX_W-1:0]];
			end
			if (op.en) begin
				if (op.all) begin
					vld_q   <= '0;
					bcast_q <= op.data;
				end else begin
					vld_q[op.sel[IDX_W-1:0]] <= 1'b1;
				end
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : rd_bcast_q;

endmodule

[rtl/dmpid_loop_mem.sv]
module dmpid_loop_mem #(
	parameter int MOTORS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [1:0]            rd_sel,
	input  dmpid_pkg::loop_op_t   op,
	output dmpid_pkg::loop_ent_t  rd_data
);

	localparam int         IDX_W   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam logic [1:0] ALL_SEL = 2'(MOTORS);

	// A cleared entry reads as zero until the next compute writes it.
	dmpid_pkg::loop_ent_t mem_q [MOTORS];
	logic [MOTORS-1:0]    vld_q;
	dmpid_pkg::loop_ent_t rd_data_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (op.wr) begin
			mem_q[op.sel[IDX_W-1:0]] <= op.data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_sel[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_sel[IDX_W-1:0]];
			end
			if (op.wr) begin
				vld_q[op.sel[IDX_W-1:0]] <= 1'b1;
			end else if (op.clr) begin
				if (op.sel == ALL_SEL) begin
					vld_q <= '0;
				end else begin
					vld_q[op.sel[IDX_W-1:0]] <= 1'b0;
				end
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

[rtl/dual_motor_incremental_pid.sv]
// Two-motor incremental PID speed controller. A compute request forms the speed error for
// the selected motor and adds Kp*(e-e1) + Ki*e + Kd*(e-2*e1+e2) to that motor's drive
// accumulator, which is clamped to plus or minus max_pulse; the response carries the
// integer part of the clamped value, or status 1 and drive 0 for a bad motor index.
// Set-target and clear requests act on one motor or, with motor_sel equal to the motor
// count, on all of them, and answer with drive 0. One request is accepted every clock
// unless the response stalls; it passes the synchronous read of the per-motor state memory
// and the three gain multiplies, then accumulate, clamp and write-back, into a registered
// response. Back-to-back requests to the same motor are served by forwarding from the
// write-back stage. A stalled response holds the whole pipeline. The user must write gains
// and the limit over the APB port only while no request is in flight; it is not enforced.
module dual_motor_incremental_pid #(
	parameter int MOTORS = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  dmpid_pkg::req_t  req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output dmpid_pkg::rsp_t  rsp,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int         IDX_W   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam logic [1:0] ALL_SEL = 2'(MOTORS);

	function automatic logic op_hits(input dmpid_pkg::loop_op_t op, input logic [1:0] sel);
		op_hits = (op.wr && op.sel == sel) ||
			(op.clr && (op.sel == sel || op.sel == ALL_SEL));
	endfunction

	dmpid_pkg::cfg_t      cfg;
	dmpid_pkg::tgt_op_t   tgt_op;
	dmpid_pkg::loop_op_t  loop_op;
	dmpid_pkg::loop_op_t  op_s2;
	dmpid_pkg::loop_op_t  wb_q;
	dmpid_pkg::loop_ent_t loop_rd;
	dmpid_pkg::loop_ent_t ent;
	dmpid_pkg::rsp_t      rsp_q;
	logic                 rsp_valid_q;
	logic                 adv;

	logic signed [dmpid_pkg::SPEED_W-1:0] tgt_rd;

	dmpid_pkg::req_t req_s1;
	logic            v_s1;
	logic            comp_s1;
	logic            bad_s1;
	logic [IDX_W-1:0] idx_s1;
	logic signed [dmpid_pkg::GAIN_W-1:0] kp_sel;
	logic signed [dmpid_pkg::GAIN_W-1:0] ki_sel;
	logic signed [dmpid_pkg::GAIN_W-1:0] kd_sel;
	logic signed [dmpid_pkg::ERR_W-1:0]  err;
	logic signed [dmpid_pkg::PA_W-1:0]   p_arg;
	logic signed [dmpid_pkg::DA_W-1:0]   d_arg;
	logic signed [dmpid_pkg::PP_W-1:0]   p_prod;
	logic signed [dmpid_pkg::PI_W-1:0]   i_prod;
	logic signed [dmpid_pkg::PD_W-1:0]   d_prod;

	logic                                v_s2;
	logic [1:0]                          cmd_s2;
	logic [1:0]                          sel_s2;
	logic                                comp_s2;
	logic                                bad_s2;
	logic signed [dmpid_pkg::PP_W-1:0]   pk_s2;
	logic signed [dmpid_pkg::PI_W-1:0]   ik_s2;
	logic signed [dmpid_pkg::PD_W-1:0]   dk_s2;
	logic signed [dmpid_pkg::ERR_W-1:0]  err_s2;
	logic signed [dmpid_pkg::ERR_W-1:0]  err1_s2;
	logic signed [dmpid_pkg::ACC_W-1:0]  acc_s2;
	logic signed [dmpid_pkg::SUM_W-1:0]  acc_sum;
	logic signed [dmpid_pkg::SUM_W-1:0]  lim;
	logic signed [dmpid_pkg::SUM_W-1:0]  acc_clamp;
	logic signed [dmpid_pkg::ACC_W-1:0]  acc_new;
	logic signed [dmpid_pkg::ACC_W-1:0]  acc_bias;

	assign adv       = !(rsp_valid_q && rsp_stall);
	assign req_stall = !adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	dmpid_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_comb begin
		tgt_op.en   = req_valid && adv && req.cmd == dmpid_pkg::CMD_SET &&
			req.motor_sel <= ALL_SEL;
		tgt_op.all  = req.motor_sel == ALL_SEL;
		tgt_op.sel  = req.motor_sel;
		tgt_op.data = req.new_target;
	end

	dmpid_tgt_mem #(
		.MOTORS (MOTORS)
	) u_tgt_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adv),
		.rd_sel  (req.motor_sel),
		.op      (tgt_op),
		.rd_data (tgt_rd)
	);

	dmpid_loop_mem #(
		.MOTORS (MOTORS)
	) u_loop_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adv),
		.rd_sel  (req.motor_sel),
		.op      (loop_op),
		.rd_data (loop_rd)
	);

	// Stage 1: resolve the history against the two writes the read missed; form the products.
	assign comp_s1 = req_s1.cmd == dmpid_pkg::CMD_COMPUTE && req_s1.motor_sel < ALL_SEL;
	assign bad_s1  = req_s1.cmd == dmpid_pkg::CMD_COMPUTE && req_s1.motor_sel >= ALL_SEL;
	assign idx_s1  = req_s1.motor_sel[IDX_W-1:0];

	always_comb begin
		if (op_hits(op_s2, req_s1.motor_sel)) begin
			ent = op_s2.wr ? op_s2.data : '0;
		end else if (op_hits(wb_q, req_s1.motor_sel)) begin
			ent = wb_q.wr ? wb_q.data : '0;
		end else begin
			ent = loop_rd;
		end
	end

	assign kp_sel = cfg.kp[idx_s1];
	assign ki_sel = cfg.ki[idx_s1];
	assign kd_sel = cfg.kd[idx_s1];

	assign err    = dmpid_pkg::ERR_W'(tgt_rd) - dmpid_pkg::ERR_W'(req_s1.measured_speed);
	assign p_arg  = dmpid_pkg::PA_W'(err) - dmpid_pkg::PA_W'(ent.e1);
	assign d_arg  = dmpid_pkg::DA_W'(err) - (dmpid_pkg::DA_W'(ent.e1) <<< 1) +
		dmpid_pkg::DA_W'(ent.e2);
	assign p_prod = kp_sel * p_arg;
	assign i_prod = ki_sel * err;
	assign d_prod = kd_sel * d_arg;

	// Stage 2: accumulate, clamp and write back.
	assign acc_sum = dmpid_pkg::SUM_W'(acc_s2) + dmpid_pkg::SUM_W'(pk_s2) +
		dmpid_pkg::SUM_W'(ik_s2) + dmpid_pkg::SUM_W'(dk_s2);
	assign lim     = dmpid_pkg::SUM_W'({cfg.max_pulse, dmpid_pkg::FRAC_W'(0)});

	always_comb begin
		if (acc_sum > lim) begin
			acc_clamp = lim;
		end else if (acc_sum < -lim) begin
			acc_clamp = -lim;
		end else begin
			acc_clamp = acc_sum;
		end
	end

	assign acc_new  = dmpid_pkg::ACC_W'(acc_clamp);
	assign acc_bias = acc_new + (acc_new[dmpid_pkg::ACC_W-1] ?
		dmpid_pkg::ACC_W'((1 << dmpid_pkg::FRAC_W) - 1) : dmpid_pkg::ACC_W'(0));

	always_comb begin
		op_s2.wr       = v_s2 && comp_s2;
		op_s2.clr      = v_s2 && cmd_s2 == dmpid_pkg::CMD_CLEAR && sel_s2 <= ALL_SEL;
		op_s2.sel      = sel_s2;
		op_s2.data.acc = acc_new;
		op_s2.data.e1  = err_s2;
		op_s2.data.e2  = err1_s2;
		loop_op        = op_s2;
		loop_op.wr     = op_s2.wr && adv;
		loop_op.clr    = op_s2.clr && adv;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1  <= req;
			cmd_s2  <= req_s1.cmd;
			sel_s2  <= req_s1.motor_sel;
			pk_s2   <= p_prod;
			ik_s2   <= i_prod;
			dk_s2   <= d_prod;
			err_s2  <= err;
			err1_s2 <= ent.e1;
			acc_s2  <= ent.acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			comp_s2     <= 1'b0;
			bad_s2      <= 1'b0;
			wb_q        <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (adv) begin
			v_s1          <= req_valid;
			v_s2          <= v_s1;
			comp_s2       <= comp_s1;
			bad_s2        <= bad_s1;
			wb_q          <= op_s2;
			rsp_valid_q   <= v_s2;
			rsp_q.drive   <= comp_s2 ? acc_bias[dmpid_pkg::ACC_W-1:dmpid_pkg::FRAC_W] : '0;
			rsp_q.status  <= bad_s2 ? dmpid_pkg::STS_BAD_MOTOR : dmpid_pkg::STS_OK;
		end
	end

	a_bad_motor_zero_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == dmpid_pkg::STS_BAD_MOTOR) |-> rsp_q.drive == '0)
		else $error("bad motor response carries a nonzero drive");

	a_drive_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |->
			(17'(rsp_q.drive) <= $signed({2'b00, cfg.max_pulse}) &&
			 17'(rsp_q.drive) >= -$signed({2'b00, cfg.max_pulse})))
		else $error("drive outside the configured limit");

	a_history_forwarded: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1 && comp_s1 && v_s2 && comp_s2 && req_s1.motor_sel == sel_s2) |=>
			err1_s2 == $past(err_s2))
		else $error("error history not forwarded between back-to-back computes");

endmodule
